[hw/rtl/mcma_pkg.sv]
// ----------------------------------------------------------------------------
// mcma_pkg
// Types and constants shared by the multichannel moving average block.
// ----------------------------------------------------------------------------
`default_nettype none
package mcma_pkg;
	localparam int DefNumChannels = 16;
	localparam int DefWindowDepth = 128;
	localparam int ChW            = 4;
	localparam int ValW           = 32;
	localparam int SumW           = 40;
	localparam int CntW           = 24;
	localparam int WinW           = 8;
	localparam logic [CntW-1:0] CumMax = {CntW{1'b1}};
	localparam logic signed [WinW-1:0] ResetWindow = 8'sd10;

	localparam logic FuncSample = 1'b0;
	localparam logic FuncClear  = 1'b1;

	typedef struct packed {
		logic                   func;
		logic [ChW-1:0]         channel;
		logic signed [ValW-1:0] sample_value;
	} in_word_t;

	typedef struct packed {
		logic [ChW-1:0]         out_channel;
		logic signed [ValW-1:0] average_value;
	} out_word_t;
endpackage
`default_nettype wire

[hw/rtl/multichannel_moving_average_top.sv]
// ----------------------------------------------------------------------------
// multichannel_moving_average_top
// Per-channel moving or cumulative average of Q16.16 samples.
// ----------------------------------------------------------------------------
// Input words carry a function bit, a channel and a sample. A sample word
// returns one output word with that channel's new average; a clear word or
// an out-of-range channel returns nothing. The window register sits on its
// own valid/ready port; it is ready only while the block is idle, a pending
// write stalls the input, and a write clears all channels.
// One word is handled at a time: the next word is taken only once the
// result of the last has been moved into the output register. The serial
// divider forms one quotient bit per cycle over a 56-bit dividend. Channel
// state lives in a small memory read and written back once per word; the
// sample ring is a memory read once.
// Reset clears the valid bits of the channel state and sets the window to
// ten; ring entries need no clearing. When the receiver stalls, the result
// waits in the output register and the next word is still taken; its result
// then keeps the block busy until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none
module multichannel_moving_average_top #(
	parameter int NumChannels = mcma_pkg::DefNumChannels,
	parameter int WindowDepth = mcma_pkg::DefWindowDepth
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire mcma_pkg::in_word_t          in_data,
	output logic                             out_valid,
	input  wire                              out_stall,
	output mcma_pkg::out_word_t              out_data,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [mcma_pkg::WinW-1:0]         cfg_data
);
	logic signed [mcma_pkg::WinW-1:0] win_q;
	logic core_busy;
	logic in_take;
	logic cfg_take;

	assign in_stall  = core_busy || cfg_valid;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = !core_busy;
	assign cfg_take  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= mcma_pkg::ResetWindow;
		else if (cfg_take)
			win_q <= cfg_data;
	end

	mcma_core #(.NumChannels(NumChannels), .WindowDepth(WindowDepth)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_data),
		.in_take  (in_take),
		.busy     (core_busy),
		.win      (win_q),
		.cfg_clear(cfg_take),
		.res_valid(out_valid),
		.res_word (out_data),
		.res_free (!out_stall)
	);

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		core_busy |-> !in_take) else $error("word taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data)) else $error("result changed");
endmodule
`default_nettype wire

[hw/rtl/mcma_div.sv]
// ----------------------------------------------------------------------------
// mcma_div
// Serial signed divider: one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module mcma_div #(
	parameter int NumW = 56,
	parameter int DenW = 25
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire signed [NumW-1:0]   num,
	input  wire        [DenW-1:0]   den,
	output logic                    done,
	output logic signed [NumW-1:0]  quot
);
	localparam int IterW = $clog2(NumW + 1);

	logic [NumW-1:0] mag_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] den_q;
	logic            neg_q;
	logic            busy_q;
	logic [IterW-1:0] iter_q;
	logic [DenW:0]   trial;
	logic [DenW:0]   diff;

	assign trial = {rem_q[DenW-1:0], mag_q[NumW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			iter_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= IterW'(NumW);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == IterW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NumW-1] ? NumW'(-num) : num;
			neg_q <= num[NumW-1];
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[DenW]) begin
				rem_q <= diff;
				mag_q <= {mag_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				mag_q <= {mag_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? NumW'(-mag_q) : mag_q;
endmodule
`default_nettype wire

[hw/rtl/mcma_core.sv]
// ----------------------------------------------------------------------------
// mcma_core
// Per-channel state memories, sample ring and the update sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module mcma_core #(
	parameter int NumChannels = mcma_pkg::DefNumChannels,
	parameter int WindowDepth = mcma_pkg::DefWindowDepth
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire mcma_pkg::in_word_t          in_word,
	input  wire                              in_take,
	output logic                             busy,
	input  wire signed [mcma_pkg::WinW-1:0]  win,
	input  wire                              cfg_clear,
	output logic                             res_valid,
	output mcma_pkg::out_word_t              res_word,
	input  wire                              res_free
);
	localparam int ChIdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;
	localparam int RingW  = $clog2(WindowDepth);
	localparam int FillW  = RingW + 1;
	localparam int StW    = RingW + FillW + mcma_pkg::SumW + mcma_pkg::ValW
		+ mcma_pkg::CntW;
	localparam int NumW   = 56;
	localparam int DenW   = mcma_pkg::CntW + 1;

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StRead  = 3'd1;
	localparam logic [2:0] StCalc  = 3'd2;
	localparam logic [2:0] StDiv   = 3'd3;
	localparam logic [2:0] StOut   = 3'd4;
	localparam logic [2:0] StLoad  = 3'd5;

	typedef struct packed {
		logic [RingW-1:0]                 head;
		logic [FillW-1:0]                 fill;
		logic signed [mcma_pkg::SumW-1:0] sum;
		logic signed [mcma_pkg::ValW-1:0] avg;
		logic [mcma_pkg::CntW-1:0]        cnt;
	} chan_st_t;

	logic [StW-1:0]              st_mem [NumChannels];
	logic [mcma_pkg::ValW-1:0]   ring_mem [NumChannels*WindowDepth];
	logic [NumChannels-1:0]      valid_q;

	logic [2:0]                  state_q;
	logic [ChIdxW-1:0]           ch_q;
	logic signed [mcma_pkg::ValW-1:0] v_q;
	chan_st_t                    st_rd_q;
	logic                        st_ok_q;
	logic [mcma_pkg::ValW-1:0]   old_rd_q;
	logic [RingW-1:0]            len_q;
	logic                        st_we;
	chan_st_t                    st_wd_q;
	logic                        div_start_q;
	logic signed [NumW-1:0]      num_q;
	logic [DenW-1:0]             den_q;
	logic                        div_done;
	logic signed [NumW-1:0]      quot;
	logic                        cum_q;
	logic                        ring_we_q;
	logic [ChIdxW+RingW-1:0]     ring_wa_q;
	logic [ChIdxW+RingW-1:0]     ring_ra;
	chan_st_t                    st_cur;
	logic [RingW-1:0]            clamp_len;
	logic signed [mcma_pkg::ValW+mcma_pkg::CntW:0] prod_s1;

	assign busy = (state_q != StIdle);
	assign clamp_len = (win > $signed({1'b0, {(mcma_pkg::WinW-1){1'b1}}})
		&& (mcma_pkg::WinW - 1 > RingW)) ? {RingW{1'b1}} :
		(($unsigned(win) > WindowDepth - 1) ? RingW'(WindowDepth - 1)
			: RingW'($unsigned(win)));
	assign st_cur = st_ok_q ? st_rd_q : '0;
	assign ring_ra = {ch_q, RingW'(st_cur.head - len_q)};

	// Channel state and ring reads are registered; the sequencer waits in StRead for the state read.
	always_ff @(posedge clk) begin
		st_rd_q  <= st_mem[ch_q];
		old_rd_q <= ring_mem[ring_ra];
		if (st_we)
			st_mem[ch_q] <= st_wd_q;
		if (ring_we_q)
			ring_mem[ring_wa_q] <= v_q;
	end

	mcma_div #(.NumW(NumW), .DenW(DenW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (num_q),
		.den   (den_q),
		.done  (div_done),
		.quot  (quot)
	);

	assign st_we = (state_q == StDiv) && div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			valid_q     <= '0;
			res_valid   <= 1'b0;
			div_start_q <= 1'b0;
			ring_we_q   <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			ring_we_q   <= 1'b0;
			if (state_q == StOut && (!res_valid || res_free))
				res_valid <= 1'b1;
			else if (res_free)
				res_valid <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (cfg_clear || (in_take && in_word.func == mcma_pkg::FuncClear))
						valid_q <= '0;
					else if (in_take && 32'(in_word.channel) < NumChannels)
						state_q <= StRead;
				end
				StRead: state_q <= StCalc;
				StCalc: state_q <= StLoad;
				StLoad: begin
					state_q     <= StDiv;
					div_start_q <= 1'b1;
				end
				StDiv: begin
					if (div_done) begin
						valid_q[ch_q] <= 1'b1;
						ring_we_q     <= !cum_q && (len_q != '0);
						state_q       <= StOut;
					end
				end
				StOut: begin
					if (!res_valid || res_free)
						state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// StCalc registers the product and the oldest ring word from the state
	// read in StRead; StLoad forms the dividend before the divider starts.
	always_ff @(posedge clk) begin
		if (state_q == StIdle && in_take) begin
			ch_q  <= ChIdxW'(in_word.channel);
			v_q   <= in_word.sample_value;
			cum_q <= win[mcma_pkg::WinW-1];
			len_q <= clamp_len;
		end
		if (state_q == StRead)
			st_ok_q <= valid_q[ch_q];
		prod_s1 <= st_cur.avg * $signed({1'b0, (st_cur.cnt < mcma_pkg::CumMax)
			? st_cur.cnt : mcma_pkg::CumMax - 1'b1});
		if (state_q == StCalc) begin
			ring_wa_q <= {ch_q, st_cur.head};
		end
		if (state_q == StLoad) begin
			if (cum_q) begin
				if (st_cur.cnt == '0) begin
					num_q <= NumW'(v_q);
					den_q <= DenW'(1);
				end else begin
					num_q <= NumW'(prod_s1) + NumW'(v_q);
					den_q <= DenW'(((st_cur.cnt < mcma_pkg::CumMax) ? st_cur.cnt
						: mcma_pkg::CumMax - 1'b1)) + 1'b1;
				end
			end else begin
				num_q <= NumW'(st_cur.sum) + NumW'(v_q);
				den_q <= DenW'(st_cur.fill) + 1'b1;
			end
		end
		if (state_q == StOut && (!res_valid || res_free)) begin
			res_word.out_channel   <= mcma_pkg::ChW'(ch_q);
			res_word.average_value <= mcma_pkg::ValW'(quot);
		end
	end

	always_comb begin
		st_wd_q = st_cur;
		st_wd_q.avg = mcma_pkg::ValW'(quot);
		if (cum_q) begin
			st_wd_q.cnt = (st_cur.cnt == '0) ? mcma_pkg::CntW'(1) :
				((st_cur.cnt < mcma_pkg::CumMax) ? st_cur.cnt + 1'b1 : mcma_pkg::CumMax);
		end else if (len_q != '0) begin
			st_wd_q.head = st_cur.head + 1'b1;
			if (st_cur.fill >= FillW'(len_q)) begin
				st_wd_q.fill = FillW'(len_q);
				st_wd_q.sum  = st_cur.sum + mcma_pkg::SumW'(v_q)
					- mcma_pkg::SumW'($signed(old_rd_q));
			end else begin
				st_wd_q.fill = st_cur.fill + 1'b1;
				st_wd_q.sum  = st_cur.sum + mcma_pkg::SumW'(v_q);
			end
		end
	end
endmodule
`default_nettype wire
